FILE: design/tpu_pkg.sv
// ----------------------------------------------------------------------------
// Toroidal position unit package
// Shared constants, request and result types and small helpers for the
// wrapping-world position pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tpu_pkg;

    // Fixed-point format and field widths.
    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int UNIT_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = CFG_IDX_W'(1);

    // World size after reset, in whole units.
    localparam int SIZE_RST = 100;

    // Signed sum or difference of two coordinates before wrapping.
    localparam int WRAP_W  = COORD_W + 2;
    localparam int INT_W   = WRAP_W - FRAC_BITS;
    localparam int REM_LAT = INT_W + 2;

    // Square root of the sum of two squared offsets.
    localparam int PROD_W   = 2 * COORD_W;
    localparam int RAD_W    = PROD_W + 2;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int ROOT_LAT = ROOT_W + 1;

    // Scaled step: product of offset and speed divided by distance.
    localparam int QUO_W   = COORD_W;
    localparam int DEN_W   = ROOT_W;
    localparam int DIV_LAT = QUO_W + 1;

    // Registers from the accepting edge to the result register.
    localparam int PIPE_REGS = 1 + REM_LAT + 3 + ROOT_LAT + DIV_LAT + REM_LAT + 1;

    typedef enum logic [1:0] {
        OP_DIST   = 2'd0,
        OP_TOWARD = 2'd1,
        OP_AWAY   = 2'd2,
        OP_STEP   = 2'd3
    } t_op;

    typedef struct packed {
        t_op                       op;
        logic [COORD_W-1:0]        pos_x;
        logic [COORD_W-1:0]        pos_y;
        logic [COORD_W-1:0]        other_x;
        logic [COORD_W-1:0]        other_y;
        logic signed [COORD_W-1:0] step_x;
        logic signed [COORD_W-1:0] step_y;
        logic [COORD_W-1:0]        speed;
    } t_req;

    typedef struct packed {
        logic [COORD_W-1:0] new_x;
        logic [COORD_W-1:0] new_y;
        logic [COORD_W-1:0] dist_res;
        logic               moved;
    } t_res;

    // A zero-sized axis behaves as one unit wide.
    function automatic logic [UNIT_W-1:0] eff_units(input logic [UNIT_W-1:0] u);
        return (u == '0) ? UNIT_W'(1) : u;
    endfunction

    // Axis size in fixed point.
    function automatic logic [COORD_W-1:0] axis_size(input logic [UNIT_W-1:0] u);
        return COORD_W'({eff_units(u), {FRAC_BITS{1'b0}}});
    endfunction

endpackage

`default_nettype wire

FILE: design/tpu_rem.sv
// ----------------------------------------------------------------------------
// Wrap pipeline
// Reduces a signed fixed-point value into the range 0 up to but not including size, one
// integer bit per stage by restoring remainder against the unit count.
// ----------------------------------------------------------------------------
`default_nettype none

module tpu_rem (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_vld,
    input  logic signed [tpu_pkg::WRAP_W-1:0]  i_val,
    input  logic [tpu_pkg::UNIT_W-1:0]         i_units,
    output logic                               o_vld,
    output logic [tpu_pkg::COORD_W-1:0]        o_val
);
    import tpu_pkg::*;

    logic signed [INT_W-1:0] w_int;
    logic [INT_W-1:0]        w_mag;
    logic [UNIT_W-1:0]       w_units;
    logic [UNIT_W-1:0]       w_fix;

    logic                    r_vld  [0:INT_W];
    logic [INT_W-1:0]        r_mag  [0:INT_W];
    logic [UNIT_W-1:0]       r_rem  [0:INT_W];
    logic                    r_neg  [0:INT_W];
    logic [FRAC_BITS-1:0]    r_frac [0:INT_W];
    logic [UNIT_W:0]         w_trial[0:INT_W-1];
    logic [UNIT_W-1:0]       n_rem  [0:INT_W-1];
    logic                    r_out_vld;
    logic [COORD_W-1:0]      r_out;

    // The integer part is taken with floor, so the fraction stays as it is.
    assign w_int   = i_val[WRAP_W-1:FRAC_BITS];
    assign w_mag   = w_int[INT_W-1] ? INT_W'(-w_int) : INT_W'(w_int);
    assign w_units = eff_units(i_units);

    // One remainder step per stage, most significant bit first.
    always_comb begin
        for (int k = 0; k < INT_W; k++) begin
            w_trial[k] = {r_rem[k], r_mag[k][INT_W-1]};
            if (w_trial[k] >= {1'b0, w_units}) begin
                n_rem[k] = UNIT_W'(w_trial[k] - {1'b0, w_units});
            end else begin
                n_rem[k] = w_trial[k][UNIT_W-1:0];
            end
        end
    end

    // A negative value with a nonzero remainder folds back from the top.
    assign w_fix = (r_neg[INT_W] && (r_rem[INT_W] != '0)) ?
                   (w_units - r_rem[INT_W]) : r_rem[INT_W];

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= INT_W; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
            for (int k = 0; k < INT_W; k++) begin
                r_vld[k+1] <= r_vld[k];
            end
            r_out_vld <= r_vld[INT_W];
        end
    end

    // Stage data.
    always_ff @(posedge i_clk) begin
        r_mag[0]  <= w_mag;
        r_rem[0]  <= '0;
        r_neg[0]  <= w_int[INT_W-1];
        r_frac[0] <= i_val[FRAC_BITS-1:0];
        for (int k = 0; k < INT_W; k++) begin
            r_mag[k+1]  <= r_mag[k] << 1;
            r_rem[k+1]  <= n_rem[k];
            r_neg[k+1]  <= r_neg[k];
            r_frac[k+1] <= r_frac[k];
        end
        r_out <= COORD_W'({w_fix, r_frac[INT_W]});
    end

    assign o_vld = r_out_vld;
    assign o_val = r_out;

endmodule

`default_nettype wire

FILE: design/tpu_root.sv
// ----------------------------------------------------------------------------
// Square root pipeline
// Floor square root of the squared distance, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tpu_root (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_vld,
    input  logic [tpu_pkg::RAD_W-1:0]        i_rad,
    output logic                             o_vld,
    output logic [tpu_pkg::ROOT_W-1:0]       o_root
);
    import tpu_pkg::*;

    localparam int RR = ROOT_W + 3;

    logic              r_vld [0:ROOT_W];
    logic [RAD_W-1:0]  r_rad [0:ROOT_W];
    logic [RR-1:0]     r_rem [0:ROOT_W];
    logic [ROOT_W-1:0] r_res [0:ROOT_W];
    logic [RR-1:0]     w_sh  [0:ROOT_W-1];
    logic [RR-1:0]     w_try [0:ROOT_W-1];
    logic              w_ge  [0:ROOT_W-1];
    logic [RR-1:0]     n_rem [0:ROOT_W-1];
    logic [ROOT_W-1:0] n_res [0:ROOT_W-1];

    // Bring down two radicand bits and try to subtract 4*res+1.
    always_comb begin
        for (int k = 0; k < ROOT_W; k++) begin
            w_sh[k]  = {r_rem[k][RR-3:0], r_rad[k][RAD_W-1 -: 2]};
            w_try[k] = RR'({r_res[k], 2'b01});
            w_ge[k]  = (w_sh[k] >= w_try[k]);
            n_rem[k] = w_ge[k] ? (w_sh[k] - w_try[k]) : w_sh[k];
            n_res[k] = {r_res[k][ROOT_W-2:0], w_ge[k]};
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= ROOT_W; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_vld;
            for (int k = 0; k < ROOT_W; k++) begin
                r_vld[k+1] <= r_vld[k];
            end
        end
    end

    // Stage data.
    always_ff @(posedge i_clk) begin
        r_rad[0] <= i_rad;
        r_rem[0] <= '0;
        r_res[0] <= '0;
        for (int k = 0; k < ROOT_W; k++) begin
            r_rad[k+1] <= r_rad[k] << 2;
            r_rem[k+1] <= n_rem[k];
            r_res[k+1] <= n_res[k];
        end
    end

    assign o_vld  = r_vld[ROOT_W];
    assign o_root = r_res[ROOT_W];

endmodule

`default_nettype wire

FILE: design/tpu_div.sv
// ----------------------------------------------------------------------------
// Divider pipeline
// Truncating division of a product by the distance, one quotient bit per
// stage. The quotient is known to fit in QUO_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tpu_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_vld,
    input  logic [tpu_pkg::PROD_W-1:0]      i_num,
    input  logic [tpu_pkg::DEN_W-1:0]       i_den,
    output logic                            o_vld,
    output logic [tpu_pkg::QUO_W-1:0]       o_quo
);
    import tpu_pkg::*;

    logic             r_vld [0:QUO_W];
    logic [DEN_W-1:0] r_rem [0:QUO_W];
    logic [QUO_W-1:0] r_low [0:QUO_W];
    logic [DEN_W-1:0] r_den [0:QUO_W];
    logic [DEN_W:0]   w_t   [0:QUO_W-1];
    logic             w_ge  [0:QUO_W-1];
    logic [DEN_W-1:0] n_rem [0:QUO_W-1];

    // Shift in the next numerator bit; the quotient bit replaces it.
    always_comb begin
        for (int k = 0; k < QUO_W; k++) begin
            w_t[k]  = {r_rem[k], r_low[k][QUO_W-1]};
            w_ge[k] = (w_t[k] >= {1'b0, r_den[k]});
            if (w_ge[k]) begin
                n_rem[k] = DEN_W'(w_t[k] - {1'b0, r_den[k]});
            end else begin
                n_rem[k] = w_t[k][DEN_W-1:0];
            end
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QUO_W; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_vld;
            for (int k = 0; k < QUO_W; k++) begin
                r_vld[k+1] <= r_vld[k];
            end
        end
    end

    // Stage data. The upper numerator half is already below the divisor.
    always_ff @(posedge i_clk) begin
        r_rem[0] <= DEN_W'(i_num[PROD_W-1:QUO_W]);
        r_low[0] <= i_num[QUO_W-1:0];
        r_den[0] <= i_den;
        for (int k = 0; k < QUO_W; k++) begin
            r_rem[k+1] <= n_rem[k];
            r_low[k+1] <= {r_low[k][QUO_W-2:0], w_ge[k]};
            r_den[k+1] <= r_den[k];
        end
    end

    assign o_vld = r_vld[QUO_W];
    assign o_quo = r_low[QUO_W];

endmodule

`default_nettype wire

FILE: design/toroidal_position_unit.sv
// ----------------------------------------------------------------------------
// Toroidal position unit
// Wrapped distance and movement of points on a world that wraps in x and y.
// ----------------------------------------------------------------------------
// Datapath: the request register, the first pair of 18-step wrap pipelines,
//   stages A to C, the 33-step square root, the 32-step divider and the
//   second pair of wrap pipelines lie before the result register.
// Throughput: one request per cycle while busy is low; the result side cannot stall.
// Reset: clears all valid bits and sets both world dimensions to 100; busy
//   is high during reset and until the run flag is registered after it.
`default_nettype none

module toroidal_position_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  tpu_pkg::t_req                   i_req,
    output logic                            o_valid,
    output tpu_pkg::t_res                   o_res,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tpu_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tpu_pkg::UNIT_W-1:0]      i_cfg_data
);
    import tpu_pkg::*;

    typedef struct packed {
        t_op                op;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] speed;
    } t_sb1;

    typedef struct packed {
        t_op                op;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] wrap_x;
        logic [COORD_W-1:0] wrap_y;
        logic               neg_x;
        logic               neg_y;
        logic [PROD_W-1:0]  prod_x;
        logic [PROD_W-1:0]  prod_y;
    } t_sb2;

    typedef struct packed {
        t_op                op;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] wrap_x;
        logic [COORD_W-1:0] wrap_y;
        logic               neg_x;
        logic               neg_y;
        logic [ROOT_W-1:0]  dist_len;
    } t_sb3;

    typedef struct packed {
        t_op                op;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] wrap_x;
        logic [COORD_W-1:0] wrap_y;
        logic [ROOT_W-1:0]  dist_len;
        logic               mv;
    } t_sb4;

    logic                r_run;
    logic [UNIT_W-1:0]   r_width;
    logic [UNIT_W-1:0]   r_height;
    logic                w_acc;

    logic                r_p0_vld;
    t_req                r_p0;
    logic signed [WRAP_W-1:0] w_v1x;
    logic signed [WRAP_W-1:0] w_v1y;

    logic                w_r1_vld;
    logic [COORD_W-1:0]  w_r1x;
    logic [COORD_W-1:0]  w_r1y;
    t_sb1                r_sb1 [0:REM_LAT-1];

    logic [COORD_W-1:0]  w_size_x;
    logic [COORD_W-1:0]  w_size_y;
    logic [COORD_W-1:0]  w_thr_x;
    logic [COORD_W-1:0]  w_thr_y;
    logic                w_neg_x;
    logic                w_neg_y;

    logic                r_a_vld;
    t_op                 r_a_op;
    logic [COORD_W-1:0]  r_a_px;
    logic [COORD_W-1:0]  r_a_py;
    logic [COORD_W-1:0]  r_a_speed;
    logic [COORD_W-1:0]  r_a_rx;
    logic [COORD_W-1:0]  r_a_ry;
    logic [COORD_W-1:0]  r_a_ax;
    logic [COORD_W-1:0]  r_a_ay;
    logic                r_a_negx;
    logic                r_a_negy;

    logic                r_b_vld;
    t_op                 r_b_op;
    logic [COORD_W-1:0]  r_b_px;
    logic [COORD_W-1:0]  r_b_py;
    logic [COORD_W-1:0]  r_b_rx;
    logic [COORD_W-1:0]  r_b_ry;
    logic                r_b_negx;
    logic                r_b_negy;
    logic [PROD_W-1:0]   r_b_sqx;
    logic [PROD_W-1:0]   r_b_sqy;
    logic [PROD_W-1:0]   r_b_prx;
    logic [PROD_W-1:0]   r_b_pry;

    logic                r_c_vld;
    logic [RAD_W-1:0]    r_c_rad;
    t_sb2                r_c_sb;

    logic                w_rt_vld;
    logic [ROOT_W-1:0]   w_dist;
    t_sb2                r_sb2 [0:ROOT_LAT-1];

    logic                w_dv_vld;
    logic [QUO_W-1:0]    w_qx;
    logic [QUO_W-1:0]    w_qy;
    t_sb3                r_sb3 [0:DIV_LAT-1];
    t_sb3                w_s3;
    logic                w_tow;
    logic signed [WRAP_W-1:0] w_v2x;
    logic signed [WRAP_W-1:0] w_v2y;
    logic                w_mv;

    logic                w_r2_vld;
    logic [COORD_W-1:0]  w_r2x;
    logic [COORD_W-1:0]  w_r2y;
    t_sb4                r_sb4 [0:REM_LAT-1];
    t_sb4                w_s4;

    logic [COORD_W-1:0]  w_nx;
    logic [COORD_W-1:0]  w_ny;
    logic [COORD_W-1:0]  w_dsat;
    logic                r_out_vld;
    t_res                r_res;

    // Handshake: requests are taken every cycle once out of reset.
    assign busy        = !r_run;
    assign o_cfg_ready = r_run;
    assign w_acc       = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= 1'b1;
        end
    end

    // World size registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= UNIT_W'(SIZE_RST);
            r_height <= UNIT_W'(SIZE_RST);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_idx)
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Request register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_vld <= 1'b0;
        end else begin
            r_p0_vld <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p0 <= i_req;
    end

    // First wrap: the step sum for a step request, else the raw offset.
    always_comb begin
        if (r_p0.op == OP_STEP) begin
            w_v1x = WRAP_W'(r_p0.pos_x) + WRAP_W'(r_p0.step_x);
            w_v1y = WRAP_W'(r_p0.pos_y) + WRAP_W'(r_p0.step_y);
        end else begin
            w_v1x = WRAP_W'(r_p0.pos_x) - WRAP_W'(r_p0.other_x);
            w_v1y = WRAP_W'(r_p0.pos_y) - WRAP_W'(r_p0.other_y);
        end
    end

    tpu_rem u_rem1_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_p0_vld),
        .i_val   (w_v1x),
        .i_units (r_width),
        .o_vld   (w_r1_vld),
        .o_val   (w_r1x)
    );

    tpu_rem u_rem1_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_p0_vld),
        .i_val   (w_v1y),
        .i_units (r_height),
        .o_vld   (),
        .o_val   (w_r1y)
    );

    // Request fields ride alongside the first wrap.
    always_ff @(posedge i_clk) begin
        r_sb1[0] <= '{op: r_p0.op, pos_x: r_p0.pos_x, pos_y: r_p0.pos_y,
                      speed: r_p0.speed};
        for (int k = 1; k < REM_LAT; k++) begin
            r_sb1[k] <= r_sb1[k-1];
        end
    end

    // Stage A: center the wrapped offset and take its magnitude.
    assign w_size_x = axis_size(r_width);
    assign w_size_y = axis_size(r_height);
    assign w_thr_x  = w_size_x - (w_size_x >> 1);
    assign w_thr_y  = w_size_y - (w_size_y >> 1);
    assign w_neg_x  = (w_r1x >= w_thr_x);
    assign w_neg_y  = (w_r1y >= w_thr_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= w_r1_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_op    <= r_sb1[REM_LAT-1].op;
        r_a_px    <= r_sb1[REM_LAT-1].pos_x;
        r_a_py    <= r_sb1[REM_LAT-1].pos_y;
        r_a_speed <= r_sb1[REM_LAT-1].speed;
        r_a_rx    <= w_r1x;
        r_a_ry    <= w_r1y;
        r_a_negx  <= w_neg_x;
        r_a_negy  <= w_neg_y;
        r_a_ax    <= w_neg_x ? (w_size_x - w_r1x) : w_r1x;
        r_a_ay    <= w_neg_y ? (w_size_y - w_r1y) : w_r1y;
    end

    // Stage B: squares and speed products.
    always_ff @(posedge i_clk) begin
        r_b_op   <= r_a_op;
        r_b_px   <= r_a_px;
        r_b_py   <= r_a_py;
        r_b_rx   <= r_a_rx;
        r_b_ry   <= r_a_ry;
        r_b_negx <= r_a_negx;
        r_b_negy <= r_a_negy;
        r_b_sqx  <= r_a_ax * r_a_ax;
        r_b_sqy  <= r_a_ay * r_a_ay;
        r_b_prx  <= r_a_ax * r_a_speed;
        r_b_pry  <= r_a_ay * r_a_speed;
    end

    // Stage C: sum of squares.
    always_ff @(posedge i_clk) begin
        r_c_rad <= RAD_W'(r_b_sqx) + RAD_W'(r_b_sqy);
        r_c_sb  <= '{op: r_b_op, pos_x: r_b_px, pos_y: r_b_py,
                     wrap_x: r_b_rx, wrap_y: r_b_ry,
                     neg_x: r_b_negx, neg_y: r_b_negy,
                     prod_x: r_b_prx, prod_y: r_b_pry};
    end

    tpu_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_c_vld),
        .i_rad   (r_c_rad),
        .o_vld   (w_rt_vld),
        .o_root  (w_dist)
    );

    always_ff @(posedge i_clk) begin
        r_sb2[0] <= r_c_sb;
        for (int k = 1; k < ROOT_LAT; k++) begin
            r_sb2[k] <= r_sb2[k-1];
        end
    end

    // Per-axis step length: offset times speed over distance.
    tpu_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_rt_vld),
        .i_num   (r_sb2[ROOT_LAT-1].prod_x),
        .i_den   (w_dist),
        .o_vld   (w_dv_vld),
        .o_quo   (w_qx)
    );

    tpu_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_rt_vld),
        .i_num   (r_sb2[ROOT_LAT-1].prod_y),
        .i_den   (w_dist),
        .o_vld   (),
        .o_quo   (w_qy)
    );

    always_ff @(posedge i_clk) begin
        r_sb3[0] <= '{op: r_sb2[ROOT_LAT-1].op,
                      pos_x: r_sb2[ROOT_LAT-1].pos_x,
                      pos_y: r_sb2[ROOT_LAT-1].pos_y,
                      wrap_x: r_sb2[ROOT_LAT-1].wrap_x,
                      wrap_y: r_sb2[ROOT_LAT-1].wrap_y,
                      neg_x: r_sb2[ROOT_LAT-1].neg_x,
                      neg_y: r_sb2[ROOT_LAT-1].neg_y,
                      dist_len: w_dist};
        for (int k = 1; k < DIV_LAT; k++) begin
            r_sb3[k] <= r_sb3[k-1];
        end
    end

    // Apply the step: toward the other point flips the offset's sign.
    assign w_s3  = r_sb3[DIV_LAT-1];
    assign w_tow = (w_s3.op == OP_TOWARD);
    assign w_mv  = ((w_s3.op == OP_TOWARD) || (w_s3.op == OP_AWAY)) &&
                   (w_s3.dist_len != '0);

    always_comb begin
        if (w_s3.neg_x != w_tow) begin
            w_v2x = WRAP_W'(w_s3.pos_x) - WRAP_W'(w_qx);
        end else begin
            w_v2x = WRAP_W'(w_s3.pos_x) + WRAP_W'(w_qx);
        end
        if (w_s3.neg_y != w_tow) begin
            w_v2y = WRAP_W'(w_s3.pos_y) - WRAP_W'(w_qy);
        end else begin
            w_v2y = WRAP_W'(w_s3.pos_y) + WRAP_W'(w_qy);
        end
    end

    tpu_rem u_rem2_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_dv_vld),
        .i_val   (w_v2x),
        .i_units (r_width),
        .o_vld   (w_r2_vld),
        .o_val   (w_r2x)
    );

    tpu_rem u_rem2_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_dv_vld),
        .i_val   (w_v2y),
        .i_units (r_height),
        .o_vld   (),
        .o_val   (w_r2y)
    );

    always_ff @(posedge i_clk) begin
        r_sb4[0] <= '{op: w_s3.op, pos_x: w_s3.pos_x, pos_y: w_s3.pos_y,
                      wrap_x: w_s3.wrap_x, wrap_y: w_s3.wrap_y,
                      dist_len: w_s3.dist_len, mv: w_mv};
        for (int k = 1; k < REM_LAT; k++) begin
            r_sb4[k] <= r_sb4[k-1];
        end
    end

    // Result selection; coincident points and distance requests keep the point.
    assign w_s4 = r_sb4[REM_LAT-1];

    always_comb begin
        if (w_s4.op == OP_STEP) begin
            w_nx = w_s4.wrap_x;
            w_ny = w_s4.wrap_y;
        end else if (w_s4.mv) begin
            w_nx = w_r2x;
            w_ny = w_r2y;
        end else begin
            w_nx = w_s4.pos_x;
            w_ny = w_s4.pos_y;
        end
    end

    assign w_dsat = (w_s4.dist_len[ROOT_W-1:COORD_W] != '0) ? '1 :
                    w_s4.dist_len[COORD_W-1:0];

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= w_r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.new_x    <= w_nx;
        r_res.new_y    <= w_ny;
        r_res.dist_res <= (w_s4.op == OP_STEP) ? '0 : w_dsat;
        r_res.moved    <= (w_s4.op != OP_DIST) &&
                          ((w_nx != w_s4.pos_x) || (w_ny != w_s4.pos_y));
    end

    assign o_valid = r_out_vld;
    assign o_res   = r_res;

    // Every result strobe matches an accepted request, delayed through the PIPE_REGS registers.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_acc, PIPE_REGS))
        else $error("result strobe without a matching request");

    // A distance request never reports a move.
    a_dist_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.moved) |-> ($past(i_req.op, PIPE_REGS) != OP_DIST))
        else $error("distance request reported a move");

    // A step request reports zero distance.
    a_step_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ($past(i_req.op, PIPE_REGS) == OP_STEP)) |-> (o_res.dist_res == '0))
        else $error("step request reported a distance");

endmodule

`default_nettype wire
